[sv/sle_pkg.sv]
// Shared types and constants of the sequential list engine.
`default_nettype none

package sle_pkg;

   localparam int unsigned SLE_DEPTH  = 64;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned POS_W      = 7;
   localparam int unsigned LEN_W      = 7;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned STATUS_W   = 2;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_GET    = 2'd2
   } sle_cmd_type;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Per-cycle control broadcast to every cell of the row.
   typedef struct packed {
      logic insert;
      logic remove;
      logic read;
   } shift_ctrl_type;

endpackage

`default_nettype wire

[sv/sle_if.sv]
// Request and response channel interfaces of the sequential list engine.
`default_nettype none

interface sle_req_if;
   logic                          valid;
   logic                          ready;
   logic [sle_pkg::CMD_W-1:0]     command;
   logic [sle_pkg::POS_W-1:0]     position;
   logic signed [sle_pkg::DATA_W-1:0] value;

   modport source (output valid, command, position, value, input ready);
   modport sink (input valid, command, position, value, output ready);
   modport monitor (input valid, ready, command, position, value);
endinterface

interface sle_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sle_pkg::STATUS_W-1:0]      status;
   logic signed [sle_pkg::DATA_W-1:0] read_value;
   logic [sle_pkg::LEN_W-1:0]         length;

   modport source (output valid, status, read_value, length, input ready);
   modport sink (input valid, status, read_value, length, output ready);
   modport monitor (input valid, ready, status, read_value, length);
endinterface

`default_nettype wire

[sv/sle_cell.sv]
// One list cell: holds one entry, shifts with its neighbors, answers a read.
`default_nettype none

module sle_cell #(
   parameter int unsigned IDXW = 6,
   parameter int unsigned IDX  = 0
) (
   input  logic                    clock,
   input  sle_pkg::shift_ctrl_type ctrl,
   input  logic [IDXW-1:0]         index,
   input  sle_pkg::data_type       ins_value,
   input  sle_pkg::data_type       left_data,
   input  sle_pkg::data_type       right_data,
   output sle_pkg::data_type       data,
   output sle_pkg::data_type       rd_data
);
   import sle_pkg::*;

   localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

   data_type entry_ff;
   data_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (MY_IDX == index) begin
            entry_in = ins_value;
         end else if (MY_IDX > index) begin
            entry_in = left_data;
         end
      end else if (ctrl.remove && (MY_IDX >= index)) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data    = entry_ff;
   assign rd_data = (ctrl.read && (MY_IDX == index)) ? entry_ff : '0;

endmodule

`default_nettype wire

[sv/sle_row.sv]
// Row of list cells chained left to right, with the read-out merge.
`default_nettype none

module sle_row #(
   parameter int unsigned DEPTH = sle_pkg::SLE_DEPTH,
   parameter int unsigned IDXW  = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  sle_pkg::shift_ctrl_type ctrl,
   input  logic [IDXW-1:0]         index,
   input  sle_pkg::data_type       ins_value,
   output sle_pkg::data_type       rd_data
);
   import sle_pkg::*;

   data_type cell_data [DEPTH];
   data_type cell_rd   [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type left_d;
      data_type right_d;

      if (i == 0) begin : g_first
         assign left_d = ins_value;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         // Nothing lies beyond the last cell; it only ever drops out of the list.
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end

      sle_cell #(
         .IDXW (IDXW),
         .IDX  (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .index      (index),
         .ins_value  (ins_value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // At most one cell drives a nonzero read term.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_data = rd_data | cell_rd[i];
      end
   end

endmodule

`default_nettype wire

[sv/sequential_list_engine.sv]
// Top level of the sequential list engine.
//
// Keeps an ordered list of up to DEPTH signed 32-bit entries in a row of
// cells. Each request on req_chan carries a command (insert, delete, get),
// a 1-based position and a value. Insert shifts every later cell up by one,
// delete shifts them down by one, get selects one cell; all cells move in
// the same clock edge, so a request completes in the cycle it is accepted.
// One response per request appears on rsp_chan the cycle after acceptance
// with a status (ok, bad position, list full), the entry read by a good get
// (zero otherwise) and the list length after the request.
// Throughput: one request per cycle. The response register is the only
// buffer: while a response waits on a stalled receiver, req_chan.ready is
// low, and it rises in the same cycle the receiver takes the response.
// Reset clears the length and the response valid; entry contents are not
// cleared, since only positions below the length are ever read.
`default_nettype none

module sequential_list_engine #(
   parameter int unsigned DEPTH = sle_pkg::SLE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   sle_req_if.sink   req_chan,
   sle_rsp_if.source rsp_chan
);
   import sle_pkg::*;

   localparam int unsigned IDXW = $clog2(DEPTH);
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned WW   = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   data_type            read_ff;
   data_type            read_in;
   logic [LEN_W-1:0]    length_ff;

   logic                accept;
   logic [WW-1:0]       pos_w;
   logic [WW-1:0]       cnt_w;
   logic                ins_pos_ok;
   logic                acc_pos_ok;
   logic                full;
   logic [IDXW-1:0]     index;
   shift_ctrl_type      ctrl;
   data_type            row_rd;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_w      = WW'(req_chan.position);
      cnt_w      = WW'(count_ff);
      ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
      acc_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
      full       = (count_ff == FULL_COUNT);
      index      = IDXW'(pos_w - WW'(1));

      ctrl.insert = accept && (req_chan.command == CMD_INSERT) && ins_pos_ok && !full;
      ctrl.remove = accept && (req_chan.command == CMD_DELETE) && acc_pos_ok;
      ctrl.read   = accept && (req_chan.command == CMD_GET) && acc_pos_ok;

      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CW'(1);
      end

      status_in = ST_RANGE;
      if ((req_chan.command == CMD_INSERT) && ins_pos_ok) begin
         status_in = full ? ST_FULL : ST_OK;
      end else if (((req_chan.command == CMD_DELETE) || (req_chan.command == CMD_GET))
                   && acc_pos_ok) begin
         status_in = ST_OK;
      end

      read_in = row_rd;

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   sle_row #(
      .DEPTH (DEPTH),
      .IDXW  (IDXW)
   ) u_row (
      .clock     (clock),
      .ctrl      (ctrl),
      .index     (index),
      .ins_value (req_chan.value),
      .rd_data   (row_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload until the next request is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         length_ff <= LEN_W'(count_in);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.read_value = read_ff;
   assign rsp_chan.length     = length_ff;

endmodule

`default_nettype wire

[sv/sle_checker.sv]
// Port-level checks of the sequential list engine and their bind.
`default_nettype none

module sle_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sle_pkg::STATUS_W-1:0] rsp_status,
   input sle_pkg::data_type            rsp_read_value,
   input logic [sle_pkg::LEN_W-1:0]    rsp_length
);
   import sle_pkg::*;

   // A response stalled by the receiver stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every accepted request shows its response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request has no response");

   // Only a good get carries a read value.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_value == '0))
      else $error("read value on a failed request");

   // A full status never shows an empty list.
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_length != '0))
      else $error("full status with empty list");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_length     (rsp_chan.length)
);

`default_nettype wire

[test/sequential_list_engine_tb.sv]
// Self-checking testbench for the sequential list engine.
module sequential_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   localparam int LIST_DEPTH = SLE_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int STALL_CYCLES = 300;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] position;
      data_type value;
   } list_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      data_type read_value;
      logic [LEN_W-1:0] length;
   } list_rsp_type;

   logic clock;
   logic reset;

   sle_req_if req_chan ();
   sle_rsp_if rsp_chan ();

   sequential_list_engine DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   list_req_type cmd_q[$];
   list_rsp_type reply_q[$];

   // predicted list contents and length
   data_type list_mem[LIST_DEPTH];
   int list_len = 0;
   // length the queued requests will leave behind, used to aim positions
   int gen_len = 0;

   int req_queued = 0;
   int req_accepted = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int phase_no = 0;
   bit hold_off = 1'b0;
   bit req_fire = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type o;
      int p;
      int j;
      o.status = ST_RANGE;
      o.read_value = '0;
      p = r.position;
      case (r.command)
         CMD_INSERT: begin
            if (p >= 1 && p <= list_len + 1) begin
               if (list_len >= LIST_DEPTH) begin
                  o.status = ST_FULL;
               end else begin
                  for (j = list_len; j > p - 1; j--) list_mem[j] = list_mem[j-1];
                  list_mem[p-1] = r.value;
                  list_len++;
                  o.status = ST_OK;
               end
            end
         end
         CMD_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               for (j = p - 1; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
               list_len--;
               o.status = ST_OK;
            end
         end
         CMD_GET: begin
            if (p >= 1 && p <= list_len) begin
               o.read_value = list_mem[p-1];
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      o.length = list_len[LEN_W-1:0];
      return o;
   endfunction

   function automatic void queue_op(logic [CMD_W-1:0] c, int p, data_type v);
      list_req_type r;
      r.command = c;
      r.position = p[POS_W-1:0];
      r.value = v;
      cmd_q.push_back(r);
      req_queued++;
      if (c == CMD_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < LIST_DEPTH)
         gen_len++;
      else if (c == CMD_DELETE && p >= 1 && p <= gen_len)
         gen_len--;
   endfunction

   // Bursts that mostly grow, mostly shrink or mix, with some noise.
   task automatic queue_random_ops(int n);
      int left;
      int burst;
      int mode;
      int roll;
      logic [CMD_W-1:0] c;
      int p;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(80, 10);
         mode = $urandom_range(2);
         while (burst > 0 && left > 0) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               c = CMD_W'($urandom_range(3));
               p = $urandom_range(127);
            end else begin
               roll = $urandom_range(99);
               case (mode)
                  0: c = (roll < 75) ? CMD_INSERT : (roll < 85) ? CMD_DELETE : CMD_GET;
                  1: c = (roll < 15) ? CMD_INSERT : (roll < 80) ? CMD_DELETE : CMD_GET;
                  default: c = (roll < 35) ? CMD_INSERT : (roll < 60) ? CMD_DELETE : CMD_GET;
               endcase
               roll = $urandom_range(99);
               if (c == CMD_INSERT) begin
                  // favor the two ends of the list
                  p = (roll < 10) ? 1 : (roll < 20) ? gen_len + 1
                                                    : $urandom_range(gen_len + 1, 1);
               end else if (gen_len == 0) begin
                  p = 1;
               end else begin
                  p = (roll < 10) ? 1 : (roll < 20) ? gen_len : $urandom_range(gen_len, 1);
               end
            end
            queue_op(c, p, data_type'($urandom));
            burst--;
            left--;
         end
      end
   endtask

   // Advance the request channel when the slot is free.
   always @(negedge clock) begin : drive_req
      list_req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = cmd_q.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.command <= nxt.command;
            req_chan.position <= nxt.position;
            req_chan.value <= nxt.value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      list_req_type got_req;
      list_rsp_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            got_req.command = req_chan.command;
            got_req.position = req_chan.position;
            got_req.value = req_chan.value;
            reply_q.push_back(apply_list_op(got_req));
            req_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (reply_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected response: status=%0d read=%0d len=%0d",
                           rsp_chan.status, rsp_chan.read_value, rsp_chan.length);
            end else begin
               want = reply_q.pop_front();
               if (rsp_chan.status !== want.status ||
                   rsp_chan.read_value !== want.read_value ||
                   rsp_chan.length !== want.length) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("mismatch: want st=%0d rd=%0d len=%0d, got st=%0d rd=%0d len=%0d",
                              want.status, want.read_value, want.length,
                              rsp_chan.status, rsp_chan.read_value, rsp_chan.length);
               end
            end
         end
      end
      req_fire = !reset && req_chan.valid && req_chan.ready;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sequential_list_engine] ERROR");
         $finish;
      end
   end

   // Hold the receiver off at the start of the last phase so the block stalls.
   initial begin
      wait (phase_no == 3);
      hold_off = 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.command = CMD_INSERT;
      req_chan.position = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;
      phase_no = 1;
      send_idle_pct = 10;
      recv_idle_pct = 52;

      // directed: empty list, bad positions, both ends, unused code
      queue_op(CMD_GET, 1, 32'sd5);
      queue_op(CMD_DELETE, 1, 32'sd0);
      queue_op(CMD_INSERT, 0, 32'sd9);
      queue_op(CMD_INSERT, 2, 32'sd9);
      queue_op(CMD_INSERT, 1, data_type'(32'h7FFF_FFFF));
      queue_op(CMD_INSERT, 1, data_type'(32'h8000_0000));
      queue_op(CMD_INSERT, 3, data_type'(32'hFFFF_FFFF));
      queue_op(CMD_INSERT, 2, 32'sd0);
      queue_op(CMD_UNUSED, 1, data_type'(32'hA5A5_5A5A));
      queue_op(CMD_GET, 1, 32'sd0);
      queue_op(CMD_GET, 2, 32'sd0);
      queue_op(CMD_GET, 3, 32'sd0);
      queue_op(CMD_GET, 4, 32'sd0);
      queue_op(CMD_GET, 5, 32'sd0);
      queue_op(CMD_GET, 127, 32'sd0);
      queue_op(CMD_DELETE, 0, 32'sd0);
      queue_op(CMD_DELETE, 5, 32'sd0);
      queue_op(CMD_DELETE, 4, 32'sd0);
      queue_op(CMD_DELETE, 1, 32'sd0);
      queue_op(CMD_GET, 1, 32'sd0);
      queue_op(CMD_GET, 2, 32'sd0);
      queue_op(CMD_GET, 3, 32'sd0);

      // fill past capacity, then a bad position and the end position on the full list
      repeat (LIST_DEPTH + 2) queue_op(CMD_INSERT, $urandom_range(gen_len + 1, 1),
                                      data_type'($urandom));
      queue_op(CMD_INSERT, LIST_DEPTH + 2, data_type'($urandom));
      queue_op(CMD_INSERT, LIST_DEPTH + 1, data_type'($urandom));
      queue_random_ops(400);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (req_accepted != req_queued) @(negedge clock);
      @(posedge clock);
      send_idle_pct = 52;
      recv_idle_pct = 10;
      phase_no = 2;
      queue_random_ops(460);

      while (req_accepted != req_queued) @(negedge clock);
      @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      phase_no = 3;
      queue_random_ops(460);

      while (req_accepted != req_queued || reply_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("[sequential_list_engine] OK");
      else
         $display("[sequential_list_engine] ERROR");
      $finish;
   end

endmodule

[sim.f]
sv/sle_pkg.sv
sv/sle_if.sv
sv/sle_cell.sv
sv/sle_row.sv
sv/sequential_list_engine.sv
sv/sle_checker.sv
test/sequential_list_engine_tb.sv
